// ===== hdl/upd_pkg.sv =====
// Shared types, constants and hex helper for the URI percent decoder.
package upd_pkg;

    localparam logic [7:0] PERCENT_CHAR = 8'h25;
    localparam logic [7:0] NUL_CHAR     = 8'h00;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned JOB_SLOTS   = 4;

    // escape tracking codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PCT  = 2'd1;
    localparam logic [1:0] PH_DIG  = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       is_terminator;
    } t_out;

    // one input byte's worth of output bytes, emitted in slot order
    typedef struct packed {
        logic [JOB_SLOTS-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      term;
    } t_job;

    // {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        return r;
    endfunction

endpackage

// ===== hdl/upd_front.sv =====
// Front end: tracks escapes and turns each input byte into a job of output bytes.
module upd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  upd_pkg::t_in  i_in,
    input  logic          i_accept,
    output upd_pkg::t_job o_job,
    output logic          o_job_push
);
    import upd_pkg::*;

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_first_digit, n_first_digit;
    t_job       job;
    logic [2:0] cnt;
    logic [4:0] hx_in, hx_fd;
    logic [7:0] b, v;
    logic       do_plain;

    always_comb begin
        b             = i_in.in_byte;
        hx_in         = hex_decode(b);
        hx_fd         = hex_decode(r_first_digit);
        v             = {hx_fd[3:0], hx_in[3:0]};
        job           = '0;
        cnt           = 3'd0;
        n_phase       = r_phase;
        n_first_digit = r_first_digit;
        do_plain      = 1'b0;

        unique case (r_phase)
            PH_PCT: begin
                if (hx_in[4]) begin
                    n_first_digit = b;
                    n_phase       = PH_DIG;
                end else begin
                    job.bytes[cnt[1:0]] = PERCENT_CHAR;
                    cnt                 = cnt + 3'd1;
                    do_plain            = 1'b1;
                end
            end
            PH_DIG: begin
                if (hx_in[4] && hx_fd[4]) begin
                    if (!v[7]) begin
                        job.bytes[cnt[1:0]] = v;
                        cnt                 = cnt + 3'd1;
                    end else begin
                        job.bytes[cnt[1:0]] = {6'b110000, v[7:6]};
                        cnt                 = cnt + 3'd1;
                        job.bytes[cnt[1:0]] = {2'b10, v[5:0]};
                        cnt                 = cnt + 3'd1;
                    end
                    n_phase = PH_IDLE;
                end else begin
                    job.bytes[cnt[1:0]] = PERCENT_CHAR;
                    cnt                 = cnt + 3'd1;
                    job.bytes[cnt[1:0]] = r_first_digit;
                    cnt                 = cnt + 3'd1;
                    do_plain            = 1'b1;
                end
            end
            default: do_plain = 1'b1;
        endcase

        if (do_plain) begin
            if (b == PERCENT_CHAR) begin
                n_phase = PH_PCT;
            end else begin
                n_phase             = PH_IDLE;
                job.bytes[cnt[1:0]] = b;
                cnt                 = cnt + 3'd1;
            end
        end

        // flush whatever escape is still held, then close the text
        if (i_in.end_of_text) begin
            if (n_phase == PH_PCT || n_phase == PH_DIG) begin
                job.bytes[cnt[1:0]] = PERCENT_CHAR;
                cnt                 = cnt + 3'd1;
            end
            if (n_phase == PH_DIG) begin
                job.bytes[cnt[1:0]] = n_first_digit;
                cnt                 = cnt + 3'd1;
            end
            job.bytes[cnt[1:0]] = NUL_CHAR;
            cnt                 = cnt + 3'd1;
            job.term            = 1'b1;
            n_phase             = PH_IDLE;
            n_first_digit       = 8'd0;
        end
        job.count = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_first_digit <= 8'd0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_first_digit <= n_first_digit;
        end
    end

    assign o_job      = job;
    assign o_job_push = i_accept && (cnt != 3'd0);

    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_in.end_of_text |=> r_phase == PH_IDLE && r_first_digit == 8'd0)
        else $error("escape state not cleared after end of text");

endmodule

// ===== hdl/upd_queue.sv =====
// Job queue between the classifying front end and the emitting back end.
module upd_queue #(
    parameter int unsigned DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  upd_pkg::t_job i_job,
    input  logic          i_pop,
    output upd_pkg::t_job o_head,
    output logic          o_empty,
    output logic          o_full
);
    import upd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en, rd_en;

    assign o_empty = (r_count == CNT_W'(0));
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("job queue count beyond depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en && !rd_en |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("job queue count lost a write");

endmodule

// ===== hdl/upd_back.sv =====
// Back end: walks each queued job slot by slot into the result register.
module upd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  upd_pkg::t_job  i_head,
    input  logic           i_q_empty,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output upd_pkg::t_out  o_out
);
    import upd_pkg::*;

    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out       r_out;
    logic       take, job_last;

    assign take     = !i_q_empty && (!r_out_valid || i_pop);
    assign job_last = ({1'b0, r_idx} + 3'd1) == i_head.count;
    assign o_q_pop  = take && job_last;
    assign o_empty  = !r_out_valid;
    assign o_out    = r_out;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.out_byte      <= i_head.bytes[r_idx];
            r_out.run_last      <= job_last;
            r_out.is_terminator <= job_last && i_head.term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_out_valid <= 1'b1;
                r_idx       <= job_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_empty |-> i_head.count != 3'd0 && {1'b0, r_idx} < i_head.count)
        else $error("slot index outside queued job");

    a_term_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.is_terminator |-> r_out.run_last && r_out.out_byte == NUL_CHAR)
        else $error("terminator not a closing zero");

endmodule

// ===== hdl/uri_percent_decoder.sv =====
// Top level of the URI percent decoder: front end, job queue and back end.
//
//  channel | direction | handshake                | payload
//  input   | in        | push / full              | i_in  (t_in: in_byte, end_of_text)
//  result  | out       | empty / pop              | o_out (t_out: out_byte, run_last,
//          |           |                          |        is_terminator)
//
// One input byte is taken per cycle while the job queue has room; a byte that
// yields k results (k is 0 to 4) holds the back end until all k have left the
// single result register, which sets the throughput. A result passes a queue
// entry and then the result register. Reset is synchronous and clears the escape
// state, the queue pointers and the result valid flag. Either side may stall
// independently; the queue of QUEUE_DEPTH jobs absorbs bursts of multi-byte results.
module uri_percent_decoder #(
    parameter int unsigned QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  upd_pkg::t_in  i_in,
    input  logic          push,
    output logic          full,
    output upd_pkg::t_out o_out,
    output logic          empty,
    input  logic          pop
);
    import upd_pkg::*;

    t_job job, head;
    logic job_push, q_empty, q_full, q_pop, in_accept;

    assign full      = q_full;
    assign in_accept = push && !q_full;

    upd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_accept   (in_accept),
        .o_job      (job),
        .o_job_push (job_push)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    upd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_out     (o_out)
    );

endmodule

// ===== tb/uri_percent_decoder_checker.sv =====
// Checker for the URI percent decoder: predicts decoded bytes and compares results.
module uri_percent_decoder_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  upd_pkg::t_in  i_req,
    input  logic          i_push,
    input  logic          i_full,
    input  upd_pkg::t_out i_res,
    input  logic          i_empty,
    input  logic          i_pop,
    output int            o_errors,
    output int            o_pending
);
    import upd_pkg::*;

    t_out       decoded_q[$];
    logic [1:0] esc_phase;
    logic [7:0] held_digit;
    int         errors;

    assign o_errors  = errors;
    assign o_pending = decoded_q.size();

    // -1 when the byte is not a hex digit
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        return -1;
    endfunction

    task automatic decode_request(input t_in req);
        logic [7:0] run[$];
        logic [7:0] v;
        t_out       r;
        int         hv;
        int         hi;
        bit         plain;
        bit         with_term;
        hv        = hex_nibble(req.in_byte);
        plain     = 1'b0;
        with_term = 1'b0;
        case (esc_phase)
            PH_PCT: begin
                if (hv >= 0) begin
                    held_digit = req.in_byte;
                    esc_phase  = PH_DIG;
                end else begin
                    run.push_back(PERCENT_CHAR);
                    plain = 1'b1;
                end
            end
            PH_DIG: begin
                hi = hex_nibble(held_digit);
                if (hv >= 0 && hi >= 0) begin
                    v = {hi[3:0], hv[3:0]};
                    if (v < 8'h80) begin
                        run.push_back(v);
                    end else begin
                        // two-byte UTF-8 form of the code point
                        run.push_back({6'b110000, v[7:6]});
                        run.push_back({2'b10, v[5:0]});
                    end
                    esc_phase = PH_IDLE;
                end else begin
                    run.push_back(PERCENT_CHAR);
                    run.push_back(held_digit);
                    plain = 1'b1;
                end
            end
            default: plain = 1'b1;
        endcase
        if (plain) begin
            if (req.in_byte == PERCENT_CHAR) begin
                esc_phase = PH_PCT;
            end else begin
                esc_phase = PH_IDLE;
                run.push_back(req.in_byte);
            end
        end
        if (req.end_of_text) begin
            // flush whatever escape is still held, then terminate
            if (esc_phase == PH_PCT) begin
                run.push_back(PERCENT_CHAR);
            end else if (esc_phase == PH_DIG) begin
                run.push_back(PERCENT_CHAR);
                run.push_back(held_digit);
            end
            run.push_back(NUL_CHAR);
            with_term  = 1'b1;
            esc_phase  = PH_IDLE;
            held_digit = 8'h00;
        end
        foreach (run[i]) begin
            r.out_byte      = run[i];
            r.run_last      = (i == run.size() - 1);
            r.is_terminator = with_term && (i == run.size() - 1);
            decoded_q.push_back(r);
        end
    endtask

    initial errors = 0;

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            esc_phase  = PH_IDLE;
            held_digit = 8'h00;
            decoded_q.delete();
        end else begin
            if (i_push && !i_full) begin
                decode_request(i_req);
            end
            if (i_pop && !i_empty) begin
                if (decoded_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected result: byte %h last %b term %b",
                                 i_res.out_byte, i_res.run_last, i_res.is_terminator);
                    end
                end else begin
                    want = decoded_q.pop_front();
                    if (want !== i_res) begin
                        errors++;
                        if (errors <= 10) begin
                            $write("mismatch: expected byte %h last %b term %b, ",
                                   want.out_byte, want.run_last, want.is_terminator);
                            $display("got byte %h last %b term %b",
                                     i_res.out_byte, i_res.run_last, i_res.is_terminator);
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== tb/uri_percent_decoder_tb.sv =====
// Testbench top for the URI percent decoder: clock, reset, stimulus and verdict.
module uri_percent_decoder_tb;
    import upd_pkg::*;

    localparam int TEXT_ITEMS = 500;
    localparam int LONG_HOLD  = 80;

    logic i_clk;
    logic i_rst_n;
    t_in  req;
    logic push;
    logic full;
    t_out res;
    logic empty;
    logic pop;

    int errors;
    int pending;
    int sent;
    bit calm;
    bit hold_req;

    uri_percent_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req),
        .push    (push),
        .full    (full),
        .o_out   (res),
        .empty   (empty),
        .pop     (pop)
    );

    uri_percent_decoder_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .i_push    (push),
        .i_full    (full),
        .i_res     (res),
        .i_empty   (empty),
        .i_pop     (pop),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        pop = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                pop      = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                pop = 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge i_clk);
            end else begin
                pop = 1'b1;
            end
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + nib;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    // a byte that breaks an escape
    function automatic logic [7:0] breaker();
        case ($urandom_range(0, 2))
            0:       return 8'($urandom_range(8'h67, 8'h7A));
            1:       return PERCENT_CHAR;
            default: return 8'($urandom_range(8'h00, 8'h2F));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eot);
        @(negedge i_clk);
        req.in_byte     = b;
        req.end_of_text = eot;
        push            = 1'b1;
        do @(posedge i_clk); while (full);
        sent++;
        if (!calm && $urandom_range(0, 7) == 0) begin
            @(negedge i_clk);
            push = 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        push = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // about half well-formed escapes with random content, the rest noise and broken escapes
    task automatic random_text();
        int         ntok;
        int         kind;
        bit         last;
        logic [7:0] v;
        ntok = $urandom_range(1, 10);
        for (int t = 0; t < ntok; t++) begin
            last = (t == ntok - 1);
            kind = $urandom_range(0, 19);
            v    = 8'($urandom_range(0, 255));
            if (kind < 10) begin
                send_byte(PERCENT_CHAR, 1'b0);
                send_byte(hex_char(v[7:4]), 1'b0);
                send_byte(hex_char(v[3:0]), last);
            end else if (kind < 15) begin
                send_byte(v, last);
            end else if (kind < 17) begin
                send_byte(PERCENT_CHAR, 1'b0);
                send_byte(breaker(), last);
            end else if (kind < 19) begin
                send_byte(PERCENT_CHAR, 1'b0);
                send_byte(hex_char(v[3:0]), 1'b0);
                send_byte(breaker(), last);
            end else begin
                // truncated escape
                if (v[0]) begin
                    send_byte(PERCENT_CHAR, last);
                end else begin
                    send_byte(PERCENT_CHAR, 1'b0);
                    send_byte(hex_char(v[7:4]), last);
                end
            end
        end
    endtask

    initial begin
        int  rand_start;
        bit  hold_done;
        bit  pause_done;
        i_rst_n    = 1'b0;
        push       = 1'b0;
        req        = '0;
        sent       = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_text("%41");
        send_text("%6a%FF%80%00%G%4%41%");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("%A");
        wait_drained();

        rand_start = sent;
        while (sent - rand_start < TEXT_ITEMS) begin
            if (!hold_done && sent - rand_start >= 150) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && sent - rand_start >= 300) begin
                wait_drained();
                pause_done = 1'b1;
            end
            if (sent - rand_start >= TEXT_ITEMS - 80) calm = 1'b1;
            random_text();
        end

        wait_drained();
        repeat (12) @(posedge i_clk);
        if (errors + pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
